// ----- hdl/tkd_pkg.sv -----
// Shared types and constants for the telnet terminal key decoder.
// Holds byte codes, key codes, state encodings and the result record.
// No dependencies.
package tkd_pkg;

    // Telnet command bytes
    localparam logic [7:0] BYTE_IAC      = 8'hFF;
    localparam logic [7:0] BYTE_OPT_LO   = 8'hFB;
    localparam logic [7:0] BYTE_OPT_HI   = 8'hFE;

    // Control bytes
    localparam logic [7:0] BYTE_ESC      = 8'h1B;
    localparam logic [7:0] BYTE_DEL      = 8'h7F;
    localparam logic [7:0] BYTE_BS       = 8'h08;
    localparam logic [7:0] BYTE_ETX      = 8'h03;
    localparam logic [7:0] BYTE_EOT      = 8'h04;
    localparam logic [7:0] BYTE_NAK      = 8'h15;
    localparam logic [7:0] BYTE_CR       = 8'h0D;
    localparam logic [7:0] BYTE_LF       = 8'h0A;
    localparam logic [7:0] BYTE_HT       = 8'h09;
    localparam logic [7:0] BYTE_SPACE    = 8'h20;

    // Escape sequence bytes
    localparam logic [7:0] CH_LBRACKET   = 8'h5B;
    localparam logic [7:0] CH_UPPER_O    = 8'h4F;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_B    = 8'h42;
    localparam logic [7:0] CH_UPPER_C    = 8'h43;
    localparam logic [7:0] CH_UPPER_D    = 8'h44;
    localparam logic [7:0] CH_UPPER_H    = 8'h48;
    localparam logic [7:0] CH_UPPER_F    = 8'h46;
    localparam logic [7:0] CH_DIGIT_3    = 8'h33;
    localparam logic [7:0] CH_TILDE      = 8'h7E;

    // UTF-8 lead and continuation masks
    localparam logic [7:0] MASK_LEAD2    = 8'hE0;
    localparam logic [7:0] LEAD2         = 8'hC0;
    localparam logic [7:0] MASK_LEAD3    = 8'hF0;
    localparam logic [7:0] LEAD3         = 8'hE0;
    localparam logic [7:0] MASK_LEAD4    = 8'hF8;
    localparam logic [7:0] LEAD4         = 8'hF0;
    localparam logic [7:0] MASK_CONT     = 8'hC0;
    localparam logic [7:0] CONT          = 8'h80;

    typedef enum logic [3:0] {
        KEY_CHAR      = 4'd0,
        KEY_ENTER     = 4'd1,
        KEY_BACKSPACE = 4'd2,
        KEY_CTRL_C    = 4'd3,
        KEY_EOF       = 4'd4,
        KEY_TAB       = 4'd5,
        KEY_CTRL_U    = 4'd6,
        KEY_UP        = 4'd7,
        KEY_DOWN      = 4'd8,
        KEY_RIGHT     = 4'd9,
        KEY_LEFT      = 4'd10,
        KEY_HOME      = 4'd11,
        KEY_END       = 4'd12,
        KEY_DELETE    = 4'd13
    } t_key_code;

    typedef enum logic [2:0] {
        TEL_IDLE = 3'b001,
        TEL_CMD  = 3'b010,
        TEL_OPT  = 3'b100
    } t_tel_state;

    typedef enum logic [4:0] {
        ESC_IDLE  = 5'b00001,
        ESC_START = 5'b00010,
        ESC_CSI   = 5'b00100,
        ESC_SS3   = 5'b01000,
        ESC_DEL3  = 5'b10000
    } t_esc_state;

    typedef struct packed {
        logic [3:0]  key_code;
        logic [31:0] char_bytes;
        logic [2:0]  char_len;
        logic        cooked_append;
        logic        mode_controlled;
    } t_result;

endpackage

// ----- hdl/tkd_in_if.sv -----
// Input byte channel of the key decoder.
// Carries valid, ready and one received byte; no dependencies.
interface tkd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// ----- hdl/tkd_out_if.sv -----
// Result channel of the key decoder.
// Carries valid, ready and one decoded key item; no dependencies.
interface tkd_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  key_code;
    logic [31:0] char_bytes;
    logic [2:0]  char_len;
    logic        cooked_append;
    logic        mode_controlled;

    modport source (output valid, output key_code, output char_bytes, output char_len,
                    output cooked_append, output mode_controlled, input ready);
    modport sink   (input valid, input key_code, input char_bytes, input char_len,
                    input cooked_append, input mode_controlled, output ready);
endinterface

// ----- hdl/tkd_cfg_if.sv -----
// Configuration write channel of the key decoder.
// Carries valid, ready and the start_controlled write data; no dependencies.
interface tkd_cfg_if;
    logic valid;
    logic ready;
    logic start_controlled;

    modport source (output valid, output start_controlled, input ready);
    modport sink   (input valid, input start_controlled, output ready);
endinterface

// ----- hdl/tkd_decode.sv -----
// Decoder state and per-byte next-state logic: telnet stripping, CR LF folding,
// escape keys, control keys and UTF-8 assembly. Depends on tkd_pkg.
module tkd_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_data_byte,
    input  logic             i_cfg_we,
    input  logic             i_cfg_start,
    output logic             o_has_result,
    output tkd_pkg::t_result o_result,
    output logic             o_mode
);

    tkd_pkg::t_tel_state r_tel, n_tel;
    tkd_pkg::t_esc_state r_esc, n_esc;
    logic        r_mode,  n_mode;
    logic        r_cr,    n_cr;
    logic [23:0] r_held,  n_held;
    logic [1:0]  r_count, n_count;
    logic [2:0]  r_needed, n_needed;

    logic [7:0]  b;
    logic        esc_key_valid;
    logic [3:0]  esc_key;
    logic [31:0] utf8_all;
    logic [2:0]  utf8_cnt;

    assign b      = i_data_byte;
    assign o_mode = r_mode;

    always_comb begin
        utf8_cnt = {1'b0, r_count} + 3'd1;
        case (r_count)
            2'd1:    utf8_all = {8'h00, r_held[23:16], b, r_held[7:0]};
            2'd2:    utf8_all = {8'h00, b, r_held[15:0]};
            default: utf8_all = {b, r_held};
        endcase
    end

    always_comb begin
        n_tel         = r_tel;
        n_esc         = r_esc;
        n_mode        = r_mode;
        n_cr          = r_cr;
        n_held        = r_held;
        n_count       = r_count;
        n_needed      = r_needed;
        esc_key_valid = 1'b0;
        esc_key       = tkd_pkg::KEY_CHAR;
        o_has_result  = 1'b0;
        o_result      = '0;
        o_result.mode_controlled = r_mode;

        if (i_accept) begin
            unique case (r_tel)
                tkd_pkg::TEL_CMD: begin
                    n_tel  = (b >= tkd_pkg::BYTE_OPT_LO && b <= tkd_pkg::BYTE_OPT_HI)
                             ? tkd_pkg::TEL_OPT : tkd_pkg::TEL_IDLE;
                    n_mode = 1'b1;
                end
                tkd_pkg::TEL_OPT: begin
                    n_tel  = tkd_pkg::TEL_IDLE;
                    n_mode = 1'b1;
                end
                default: begin
                    if (b == tkd_pkg::BYTE_IAC) begin
                        n_tel  = tkd_pkg::TEL_CMD;
                        n_mode = 1'b1;
                    end else if (b == tkd_pkg::BYTE_LF && r_cr) begin
                        n_cr = 1'b0;
                    end else begin
                        n_cr = (b == tkd_pkg::BYTE_CR);
                        if (r_esc != tkd_pkg::ESC_IDLE) begin
                            // any byte that does not continue the sequence ends it
                            n_esc = tkd_pkg::ESC_IDLE;
                            unique case (r_esc)
                                tkd_pkg::ESC_START: begin
                                    if (b == tkd_pkg::CH_LBRACKET) n_esc = tkd_pkg::ESC_CSI;
                                    else if (b == tkd_pkg::CH_UPPER_O) n_esc = tkd_pkg::ESC_SS3;
                                end
                                tkd_pkg::ESC_CSI: begin
                                    esc_key_valid = 1'b1;
                                    case (b)
                                        tkd_pkg::CH_UPPER_A: esc_key = tkd_pkg::KEY_UP;
                                        tkd_pkg::CH_UPPER_B: esc_key = tkd_pkg::KEY_DOWN;
                                        tkd_pkg::CH_UPPER_C: esc_key = tkd_pkg::KEY_RIGHT;
                                        tkd_pkg::CH_UPPER_D: esc_key = tkd_pkg::KEY_LEFT;
                                        tkd_pkg::CH_UPPER_H: esc_key = tkd_pkg::KEY_HOME;
                                        tkd_pkg::CH_UPPER_F: esc_key = tkd_pkg::KEY_END;
                                        default: begin
                                            esc_key_valid = 1'b0;
                                            if (b == tkd_pkg::CH_DIGIT_3)
                                                n_esc = tkd_pkg::ESC_DEL3;
                                        end
                                    endcase
                                end
                                tkd_pkg::ESC_SS3: begin
                                    if (b == tkd_pkg::CH_UPPER_H) begin
                                        esc_key_valid = 1'b1;
                                        esc_key       = tkd_pkg::KEY_HOME;
                                    end else if (b == tkd_pkg::CH_UPPER_F) begin
                                        esc_key_valid = 1'b1;
                                        esc_key       = tkd_pkg::KEY_END;
                                    end
                                end
                                tkd_pkg::ESC_DEL3: begin
                                    if (b == tkd_pkg::CH_TILDE) begin
                                        esc_key_valid = 1'b1;
                                        esc_key       = tkd_pkg::KEY_DELETE;
                                    end
                                end
                                default: ;
                            endcase
                            // cooked mode discards escape keys
                            if (esc_key_valid && r_mode) begin
                                o_has_result      = 1'b1;
                                o_result.key_code = esc_key;
                            end
                        end else if (b == tkd_pkg::BYTE_ESC) begin
                            n_esc = tkd_pkg::ESC_START;
                        end else if (b < tkd_pkg::BYTE_SPACE || b == tkd_pkg::BYTE_DEL) begin
                            o_has_result = 1'b1;
                            case (b)
                                tkd_pkg::BYTE_CR, tkd_pkg::BYTE_LF:
                                    o_result.key_code = tkd_pkg::KEY_ENTER;
                                tkd_pkg::BYTE_DEL, tkd_pkg::BYTE_BS:
                                    o_result.key_code = tkd_pkg::KEY_BACKSPACE;
                                tkd_pkg::BYTE_ETX: o_result.key_code = tkd_pkg::KEY_CTRL_C;
                                tkd_pkg::BYTE_EOT: o_result.key_code = tkd_pkg::KEY_EOF;
                                tkd_pkg::BYTE_HT:  o_result.key_code = tkd_pkg::KEY_TAB;
                                tkd_pkg::BYTE_NAK: o_result.key_code = tkd_pkg::KEY_CTRL_U;
                                default:           o_has_result      = 1'b0;
                            endcase
                        end else if (!b[7]) begin
                            o_has_result           = 1'b1;
                            o_result.key_code      = tkd_pkg::KEY_CHAR;
                            o_result.char_bytes    = {24'h0, b};
                            o_result.char_len      = 3'd1;
                            o_result.cooked_append = !r_mode;
                        end else if (r_count == 2'd0) begin
                            // lead byte: pick length or drop
                            n_held  = {16'h0, b};
                            n_count = 2'd1;
                            if ((b & tkd_pkg::MASK_LEAD2) == tkd_pkg::LEAD2) begin
                                n_needed = 3'd2;
                            end else if ((b & tkd_pkg::MASK_LEAD3) == tkd_pkg::LEAD3) begin
                                n_needed = 3'd3;
                            end else if ((b & tkd_pkg::MASK_LEAD4) == tkd_pkg::LEAD4) begin
                                n_needed = 3'd4;
                            end else begin
                                n_held   = '0;
                                n_count  = 2'd0;
                                n_needed = 3'd0;
                            end
                        end else if ((b & tkd_pkg::MASK_CONT) != tkd_pkg::CONT) begin
                            n_held   = '0;
                            n_count  = 2'd0;
                            n_needed = 3'd0;
                        end else if (utf8_cnt >= r_needed) begin
                            o_has_result           = 1'b1;
                            o_result.key_code      = tkd_pkg::KEY_CHAR;
                            o_result.char_bytes    = utf8_all;
                            o_result.char_len      = utf8_cnt;
                            o_result.cooked_append = !r_mode;
                            n_held   = '0;
                            n_count  = 2'd0;
                            n_needed = 3'd0;
                        end else begin
                            n_held  = utf8_all[23:0];
                            n_count = utf8_cnt[1:0];
                        end
                    end
                end
            endcase
        end

        if (i_cfg_we) begin
            n_mode = i_cfg_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tel    <= tkd_pkg::TEL_IDLE;
            r_esc    <= tkd_pkg::ESC_IDLE;
            r_mode   <= 1'b0;
            r_cr     <= 1'b0;
            r_held   <= '0;
            r_count  <= 2'd0;
            r_needed <= 3'd0;
        end else begin
            r_tel    <= n_tel;
            r_esc    <= n_esc;
            r_mode   <= n_mode;
            r_cr     <= n_cr;
            r_held   <= n_held;
            r_count  <= n_count;
            r_needed <= n_needed;
        end
    end

endmodule

// ----- hdl/tkd_outbuf.sv -----
// Two-entry result buffer: output register plus skid register, so input ready
// comes from a flop. Depends on tkd_pkg and tkd_out_if.
module tkd_outbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tkd_pkg::t_result i_result,
    output logic             o_in_ready,
    tkd_out_if.source        o_out
);

    tkd_pkg::t_result r_out, r_skid;
    logic             r_out_valid, r_skid_valid;
    logic             pop;

    assign pop        = r_out_valid && o_out.ready;
    assign o_in_ready = !r_skid_valid;

    assign o_out.valid           = r_out_valid;
    assign o_out.key_code        = r_out.key_code;
    assign o_out.char_bytes      = r_out.char_bytes;
    assign o_out.char_len        = r_out.char_len;
    assign o_out.cooked_append   = r_out.cooked_append;
    assign o_out.mode_controlled = r_out.mode_controlled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // drain the skid entry first; no push while it is full
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid <= i_result;
            end else begin
                r_out <= i_result;
            end
        end
    end

endmodule

// ----- hdl/telnet_terminal_key_decoder.sv -----
// Top level of the telnet terminal key decoder.
// Depends on tkd_pkg, tkd_in_if, tkd_out_if, tkd_cfg_if, tkd_decode, tkd_outbuf.

// Takes one received byte per clock and gives at most one key item per byte,
// registered after the byte is accepted. The whole decode (telnet
// command stripping, CR LF folding, escape keys, control keys, UTF-8 assembly)
// is one pass of logic between the byte handshake and the result register, so
// the sustained rate is one byte per cycle. A two-entry result buffer keeps
// input ready registered: bytes keep flowing while one result waits, and input
// stalls only once two results are held. Writing start_controlled also reloads
// the current mode; the first telnet command switches to controlled mode.
module telnet_terminal_key_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tkd_in_if.sink    i_in,
    tkd_cfg_if.sink   i_cfg,
    tkd_out_if.source o_out
);

    logic             accept;
    logic             cfg_we;
    logic             has_result;
    logic             in_ready;
    logic             mode;
    tkd_pkg::t_result result;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_in.valid && in_ready;
    assign cfg_we      = i_cfg.valid;

    tkd_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_in.data_byte),
        .i_cfg_we     (cfg_we),
        .i_cfg_start  (i_cfg.start_controlled),
        .o_has_result (has_result),
        .o_result     (result),
        .o_mode       (mode)
    );

    tkd_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept && has_result),
        .i_result   (result),
        .o_in_ready (in_ready),
        .o_out      (o_out)
    );

`ifndef SYNTHESIS
    a_iac_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.data_byte == tkd_pkg::BYTE_IAC) |-> !has_result)
        else $error("telnet IAC byte produced a key item");

    a_iac_sets_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.data_byte == tkd_pkg::BYTE_IAC && !cfg_we) |=> mode)
        else $error("telnet IAC byte did not switch to controlled mode");

    a_stall_needs_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> o_out.valid)
        else $error("input stalled with no result waiting");

    a_len_only_chars: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (has_result && result.char_len != 3'd0) |-> result.key_code == tkd_pkg::KEY_CHAR)
        else $error("non-character key carries character bytes");
`endif

endmodule

// ----- dv/tkd_checker.sv -----
// Key decoder checker: watches the byte, configuration and key channels,
// predicts each key item and compares it field by field.
// Depends on tkd_pkg, tkd_in_if, tkd_cfg_if, tkd_out_if.
module tkd_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    tkd_in_if    i_in,
    tkd_cfg_if   i_cfg,
    tkd_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import tkd_pkg::*;

    localparam logic [3:0] NO_KEY = 4'hF;

    t_result     expected_keys[$];
    t_tel_state  tn_phase;
    t_esc_state  esc_phase;
    logic        cr_seen;
    logic [23:0] utf_held;
    logic [2:0]  utf_count;
    logic [2:0]  utf_needed;
    logic        ctl_mode;
    int          fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic void queue_key(input logic [3:0] key, input logic [31:0] bytes,
                                      input logic [2:0] len, input logic cooked);
        t_result r;
        r.key_code        = key;
        r.char_bytes      = bytes;
        r.char_len        = len;
        r.cooked_append   = cooked;
        r.mode_controlled = ctl_mode;
        expected_keys.insert(expected_keys.size(), r);
    endfunction

    function automatic void utf_drop();
        utf_held   = '0;
        utf_count  = '0;
        utf_needed = '0;
    endfunction

    task automatic predict_byte(input logic [7:0] b);
        logic [3:0]  key;
        t_esc_state  nxt;
        logic [31:0] all;
        logic [2:0]  cnt;
        key = NO_KEY;
        nxt = ESC_IDLE;

        // telnet command bytes are swallowed and force controlled mode
        if (tn_phase == TEL_CMD) begin
            tn_phase = (b >= BYTE_OPT_LO && b <= BYTE_OPT_HI) ? TEL_OPT : TEL_IDLE;
            ctl_mode = 1'b1;
            return;
        end
        if (tn_phase == TEL_OPT) begin
            tn_phase = TEL_IDLE;
            ctl_mode = 1'b1;
            return;
        end
        tn_phase = TEL_IDLE;
        if (b == BYTE_IAC) begin
            tn_phase = TEL_CMD;
            ctl_mode = 1'b1;
            return;
        end

        if (b == BYTE_LF && cr_seen) begin
            cr_seen = 1'b0;
            return;
        end
        cr_seen = (b == BYTE_CR);

        if (esc_phase == ESC_IDLE) begin
            if (b == BYTE_ESC) begin
                esc_phase = ESC_START;
                return;
            end
        end else begin
            case (esc_phase)
                ESC_START: begin
                    if (b == CH_LBRACKET) nxt = ESC_CSI;
                    else if (b == CH_UPPER_O) nxt = ESC_SS3;
                end
                ESC_CSI: begin
                    case (b)
                        CH_UPPER_A: key = KEY_UP;
                        CH_UPPER_B: key = KEY_DOWN;
                        CH_UPPER_C: key = KEY_RIGHT;
                        CH_UPPER_D: key = KEY_LEFT;
                        CH_UPPER_H: key = KEY_HOME;
                        CH_UPPER_F: key = KEY_END;
                        CH_DIGIT_3: nxt = ESC_DEL3;
                        default: ;
                    endcase
                end
                ESC_SS3: begin
                    if (b == CH_UPPER_H) key = KEY_HOME;
                    else if (b == CH_UPPER_F) key = KEY_END;
                end
                ESC_DEL3: begin
                    if (b == CH_TILDE) key = KEY_DELETE;
                end
                default: ;
            endcase
            esc_phase = nxt;
            // cooked mode throws escape keys away
            if (key != NO_KEY && ctl_mode) queue_key(key, '0, '0, 1'b0);
            return;
        end

        case (b)
            BYTE_CR, BYTE_LF:  key = KEY_ENTER;
            BYTE_DEL, BYTE_BS: key = KEY_BACKSPACE;
            BYTE_ETX:          key = KEY_CTRL_C;
            BYTE_EOT:          key = KEY_EOF;
            BYTE_HT:           key = KEY_TAB;
            BYTE_NAK:          key = KEY_CTRL_U;
            default: ;
        endcase
        if (key != NO_KEY) begin
            queue_key(key, '0, '0, 1'b0);
            return;
        end

        if (b >= BYTE_SPACE && b < BYTE_DEL) begin
            queue_key(KEY_CHAR, {24'h0, b}, 3'd1, !ctl_mode);
            return;
        end
        if (b < CONT) return;

        if (utf_count == 0) begin
            if ((b & MASK_LEAD2) == LEAD2) utf_needed = 3'd2;
            else if ((b & MASK_LEAD3) == LEAD3) utf_needed = 3'd3;
            else if ((b & MASK_LEAD4) == LEAD4) utf_needed = 3'd4;
            else begin
                utf_drop();
                return;
            end
            utf_held  = {16'h0, b};
            utf_count = 3'd1;
            return;
        end
        if ((b & MASK_CONT) != CONT || utf_count > 3) begin
            utf_drop();
            return;
        end
        all = {8'h0, utf_held} | (32'(b) << (8 * utf_count));
        cnt = utf_count + 3'd1;
        if (cnt >= utf_needed) begin
            utf_drop();
            queue_key(KEY_CHAR, all, cnt, !ctl_mode);
        end else begin
            utf_held  = all[23:0];
            utf_count = cnt;
        end
    endtask

    task automatic check_key();
        t_result want;
        if (expected_keys.size() == 0) begin
            $error("key item with none expected: key_code %0d char_bytes %h",
                   i_out.key_code, i_out.char_bytes);
            fail_count++;
            return;
        end
        want = expected_keys.pop_front();
        if (i_out.key_code !== want.key_code) begin
            $error("key_code: expected %0d, actual %0d", want.key_code, i_out.key_code);
            fail_count++;
        end
        if (i_out.char_bytes !== want.char_bytes) begin
            $error("char_bytes: expected %h, actual %h", want.char_bytes, i_out.char_bytes);
            fail_count++;
        end
        if (i_out.char_len !== want.char_len) begin
            $error("char_len: expected %0d, actual %0d", want.char_len, i_out.char_len);
            fail_count++;
        end
        if (i_out.cooked_append !== want.cooked_append) begin
            $error("cooked_append: expected %0d, actual %0d",
                   want.cooked_append, i_out.cooked_append);
            fail_count++;
        end
        if (i_out.mode_controlled !== want.mode_controlled) begin
            $error("mode_controlled: expected %0d, actual %0d",
                   want.mode_controlled, i_out.mode_controlled);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tn_phase  = TEL_IDLE;
            esc_phase = ESC_IDLE;
            cr_seen   = 1'b0;
            ctl_mode  = 1'b0;
            utf_drop();
            expected_keys.delete();
        end else begin
            // compare first: a key item never leaves on the edge its byte enters
            if (i_out.valid && i_out.ready) check_key();
            if (i_cfg.valid && i_cfg.ready) ctl_mode = i_cfg.start_controlled;
            if (i_in.valid && i_in.ready) predict_byte(i_in.data_byte);
        end
        o_pending <= expected_keys.size();
    end

endmodule

// ----- dv/tb.sv -----
// Testbench top for the telnet terminal key decoder: clock, reset, byte and
// mode stimulus, key channel back-pressure and the final verdict.
// Depends on tkd_pkg, the channel interfaces, the decoder and tkd_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tkd_pkg::*;

    localparam int BYTE_TARGET = 650;
    localparam int PHASES      = 8;
    localparam int CYCLE_LIMIT = 200000;

    // cooked escape, CR LF, NUL, cooked UTF-8, telnet option command, delete,
    // SS3 end, CR inside an escape followed by LF, 4-byte UTF-8
    localparam logic [7:0] OPENING_BYTES [25] = '{
        BYTE_ESC, CH_LBRACKET, CH_UPPER_A,
        BYTE_CR, BYTE_LF,
        8'h00,
        8'hC3, 8'hA9,
        BYTE_IAC, BYTE_OPT_LO, 8'h01,
        BYTE_ESC, CH_LBRACKET, CH_DIGIT_3, CH_TILDE,
        BYTE_ESC, CH_UPPER_O, CH_UPPER_F,
        BYTE_ESC, BYTE_CR, BYTE_LF,
        8'hF0, 8'h9F, 8'h98, 8'h80
    };
    localparam logic [7:0] CTRL_KEYS [8] = '{
        BYTE_CR, BYTE_LF, BYTE_DEL, BYTE_BS, BYTE_ETX, BYTE_EOT, BYTE_HT, BYTE_NAK
    };
    localparam logic [7:0] CSI_FINALS [6] = '{
        CH_UPPER_A, CH_UPPER_B, CH_UPPER_C, CH_UPPER_D, CH_UPPER_H, CH_UPPER_F
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending_keys;
    int   cycle_count = 0;
    int   bytes_sent  = 0;
    int   ready_hold  = 0;
    int   stall_draw;
    bit   steady;

    tkd_in_if  in_ch ();
    tkd_cfg_if cfg_ch ();
    tkd_out_if out_ch ();

    telnet_terminal_key_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    tkd_checker key_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_cfg        (cfg_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_keys)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("telnet_terminal_key_decoder regression: fail");
            $finish;
        end
    end

    // key channel: hold ready low for a drawn number of cycles after each item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            ready_hold   <= 0;
        end else if (out_ch.valid && out_ch.ready) begin
            stall_draw = steady ? 0 : $urandom_range(0, 6);
            ready_hold   <= stall_draw;
            out_ch.ready <= (stall_draw == 0);
        end else if (ready_hold > 1) begin
            ready_hold <= ready_hold - 1;
        end else begin
            ready_hold   <= 0;
            out_ch.ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        bytes_sent++;
    endtask

    // drop valid and hold until every key item is out and the pipe is quiet
    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_keys != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        cfg_ch.valid            <= 1'b1;
        cfg_ch.start_controlled <= mode;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_escape();
        int         form;
        logic [7:0] tail;
        form = $urandom_range(0, 3);
        send_byte(BYTE_ESC);
        case (form)
            0: begin
                send_byte(CH_LBRACKET);
                tail = CSI_FINALS[$urandom_range(0, 5)];
            end
            1: begin
                send_byte(CH_UPPER_O);
                tail = $urandom_range(0, 1) ? CH_UPPER_H : CH_UPPER_F;
            end
            2: begin
                send_byte(CH_LBRACKET);
                send_byte(CH_DIGIT_3);
                tail = CH_TILDE;
            end
            default: tail = 8'($urandom_range(0, 255));
        endcase
        // break the sequence now and then
        if ($urandom_range(0, 4) == 0) tail = 8'($urandom_range(0, 255));
        send_byte(tail);
    endtask

    task automatic send_utf8();
        int         len;
        logic [7:0] lead;
        logic [7:0] cont;
        len = $urandom_range(2, 4);
        case (len)
            2:       lead = LEAD2 | 8'($urandom_range(0, 31));
            3:       lead = LEAD3 | 8'($urandom_range(0, 15));
            default: lead = LEAD4 | 8'($urandom_range(0, 7));
        endcase
        if ($urandom_range(0, 9) == 0) lead = 8'($urandom_range(8'h80, 8'hFE));
        send_byte(lead);
        for (int k = 1; k < len; k++) begin
            // plain bytes in the middle must not disturb the pending character
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1)) send_byte(8'($urandom_range(8'h20, 8'h7E)));
                else send_byte(CTRL_KEYS[$urandom_range(2, 7)]);
            end
            cont = CONT | 8'($urandom_range(0, 63));
            if ($urandom_range(0, 11) == 0) cont = 8'($urandom_range(0, 255));
            send_byte(cont);
        end
    endtask

    task automatic send_telnet();
        send_byte(BYTE_IAC);
        if ($urandom_range(0, 1)) send_byte(8'($urandom_range(BYTE_OPT_LO, BYTE_OPT_HI)));
        send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_random_sequence(input bit keep_cooked);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            send_byte(8'($urandom_range(8'h20, 8'h7E)));
        end else if (pick < 30) begin
            if ($urandom_range(0, 3) == 0) send_byte(8'($urandom_range(0, 31)));
            else send_byte(CTRL_KEYS[$urandom_range(0, 7)]);
        end else if (pick < 36) begin
            send_byte(BYTE_CR);
            send_byte(BYTE_LF);
        end else if (pick < 58) begin
            send_escape();
        end else if (pick < 80) begin
            send_utf8();
        end else if (pick < (keep_cooked ? 82 : 90)) begin
            send_telnet();
        end else begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int   phase_end;
        logic mode;
        in_ch.valid             = 1'b0;
        in_ch.data_byte         = '0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.start_controlled = 1'b0;
        out_ch.ready            = 1'b0;
        steady                  = 1'b0;
        i_rst_n                 = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (OPENING_BYTES[i]) send_byte(OPENING_BYTES[i]);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            mode = (p < 2) ? p[0] : 1'($urandom_range(0, 1));
            write_mode(mode);
            steady    = (p % 3 == 1);
            phase_end = bytes_sent + BYTE_TARGET / PHASES;
            while (bytes_sent < phase_end) send_random_sequence(!mode);
        end
        steady = 1'b0;
        settle();

        if (fail_count == 0) begin
            $display("telnet_terminal_key_decoder regression: pass");
        end else begin
            $display("telnet_terminal_key_decoder regression: fail");
        end
        $finish;
    end

endmodule
